### src/msl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package msl_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 4;
    localparam int RATE_W   = 5;
    localparam int GAIN_W   = 18;
    localparam int PROD_W   = GAIN_W + SAMPLE_W;
    localparam int SUM_W    = GAIN_W + 1;
    localparam int FRAC_W   = 16;

    // Predictor quantization and ramp length
    localparam int QUANT_STEPS    = 16;
    localparam int INTERP_MS      = 8;
    localparam int GAIN_OFFSET    = -65536;
    localparam int QUANT_STEP_Q16 = (1 << 17) / (QUANT_STEPS - 1);
    localparam int RAMP_W         = $clog2(INTERP_MS * ((1 << RATE_W) - 1) + 1);
    localparam int GAIN_MAX       = (1 << (GAIN_W - 1)) - 1;
    localparam int GAIN_MIN       = -(1 << (GAIN_W - 1));
    localparam int RAW_W          = 32;

    // Divider iteration counter
    localparam int DIV_CNT_W = $clog2(GAIN_W + 1);

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(16);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_GAIN,
        ST_MUL,
        ST_SUM,
        ST_OUT
    } msl_state_t;

    typedef struct packed {
        logic mul_en;
        logic sum_en;
    } mix_ctrl_t;

    // Dequantize a predictor index to a saturated Q16 gain
    function automatic logic signed [GAIN_W-1:0] quant_gain(input logic [INDEX_W-1:0] idx);
        logic signed [RAW_W-1:0] raw;
        raw = RAW_W'(GAIN_OFFSET) + RAW_W'($signed({1'b0, idx})) * RAW_W'(QUANT_STEP_Q16);
        if (raw > RAW_W'(GAIN_MAX)) begin
            return GAIN_W'(GAIN_MAX);
        end
        else if (raw < RAW_W'(GAIN_MIN)) begin
            return GAIN_W'(GAIN_MIN);
        end
        return raw[GAIN_W-1:0];
    endfunction

    // Clamp a sum to the sample range
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'((1 << (SAMPLE_W - 1)) - 1);
        lo = -SUM_W'(1 << (SAMPLE_W - 1));
        if (v > hi) begin
            return hi[SAMPLE_W-1:0];
        end
        else if (v < lo) begin
            return lo[SAMPLE_W-1:0];
        end
        return v[SAMPLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

### src/msl_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring serial divider: one quotient bit per cycle, truncates toward zero
module msl_div
    import msl_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [GAIN_W-1:0]        dividend_mag,
    input  wire logic                     negate,
    input  wire logic [RAMP_W-1:0]        divisor,
    output logic                          done,
    output logic signed [GAIN_W-1:0]      quotient
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [GAIN_W-1:0]     quo_reg, quo_next;
    logic [RAMP_W-1:0]     rem_reg, rem_next;
    logic [RAMP_W-1:0]     dsr_reg;
    logic                  neg_reg;
    logic [RAMP_W:0]       shifted;
    logic                  fits;

    // Control registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            dsr_reg <= divisor;
            neg_reg <= negate;
        end
    end

    assign shifted = {rem_reg, quo_reg[GAIN_W-1]};
    assign fits    = shifted >= {1'b0, dsr_reg};

    // Iterate one bit per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(GAIN_W);
            quo_next  = dividend_mag;
            rem_next  = '0;
        end
        else if (busy_reg) begin
            if (fits) begin
                rem_next = RAMP_W'(shifted - {1'b0, dsr_reg});
            end
            else begin
                rem_next = shifted[RAMP_W-1:0];
            end
            quo_next = {quo_reg[GAIN_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

`default_nettype wire

### src/msl_mix.sv
`timescale 1ns / 1ps
`default_nettype none

// Side prediction and left/right matrix
module msl_mix
    import msl_pkg::*;
(
    input  wire logic                       clk,
    input  wire mix_ctrl_t                  ctrl,
    input  wire logic signed [GAIN_W-1:0]   gain,
    input  wire logic signed [SAMPLE_W-1:0] mid,
    input  wire logic signed [SAMPLE_W-1:0] side,
    output logic signed [SAMPLE_W-1:0]      left,
    output logic signed [SAMPLE_W-1:0]      right
);

    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SAMPLE_W-1:0] side_reg;
    logic signed [GAIN_W-1:0]   pred;
    logic signed [SUM_W-1:0]    side_sum;

    // Floor of the Q16 product is an arithmetic shift
    assign pred     = prod_reg[PROD_W-1:FRAC_W];
    assign side_sum = SUM_W'(side) + SUM_W'(pred);

    // Multiply, then add the prediction
    always_ff @(posedge clk) begin
        if (ctrl.mul_en) begin
            prod_reg <= PROD_W'(gain) * PROD_W'(mid);
        end
        if (ctrl.sum_en) begin
            side_reg <= sat_sample(side_sum);
        end
    end

    assign left  = sat_sample(SUM_W'(mid) + SUM_W'(side_reg));
    assign right = sat_sample(SUM_W'(mid) - SUM_W'(side_reg));

endmodule

`default_nettype wire

### src/mid_side_to_left_right.sv
// Mid/side to left/right stereo reconstruction with a ramped side predictor.
//
// Input channel (in_valid / in_stall): one mid and one side sample per item;
// frame_start marks a frame's first item and latches predictor_index.
// Output channel (out_valid / out_stall): one left/right pair per item.
// Config channel (cfg_valid / cfg_ready): writes sample_rate_khz; always ready.
//
// A plain item passes through the gain, multiply, add and output states after
// acceptance, and the input is stalled until the item leaves the output state,
// so no new item is taken before the last one is through. A frame start that
// changes the gain, with a nonzero ramp length, first runs a serial divide for
// the ramp step in the divide state: the divider works out the quotient bit by
// bit and the sequencer collects it before the gain state.
//
// Reset clears the latched, current and target gains, step and ramp, sets
// sample_rate_khz to 16 and empties the output register. When the receiver
// stalls, the result is held in the output register; a following item is
// taken and worked on, and its final step waits for a free output register.
`timescale 1ns / 1ps
`default_nettype none

module mid_side_to_left_right
    import msl_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [RATE_W-1:0]          cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic signed [SAMPLE_W-1:0] mid_sample,
    input  wire logic signed [SAMPLE_W-1:0] side_sample,
    input  wire logic                       frame_start,
    input  wire logic [INDEX_W-1:0]         predictor_index,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic signed [SAMPLE_W-1:0]      left_sample,
    output logic signed [SAMPLE_W-1:0]      right_sample
);

    msl_state_t                 state_reg, state_next;
    logic [RATE_W-1:0]          rate_reg;
    logic signed [GAIN_W-1:0]   prev_gain_reg, prev_gain_next;
    logic signed [GAIN_W-1:0]   cur_gain_reg, cur_gain_next;
    logic signed [GAIN_W-1:0]   step_reg, step_next;
    logic signed [GAIN_W-1:0]   target_reg, target_next;
    logic [RAMP_W-1:0]          ramp_reg, ramp_next;
    logic signed [GAIN_W-1:0]   gain_reg, gain_next;
    logic signed [SAMPLE_W-1:0] mid_reg;
    logic signed [SAMPLE_W-1:0] side_reg;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] left_reg;
    logic signed [SAMPLE_W-1:0] right_reg;

    logic                       accept;
    logic                       out_free;
    logic                       out_load;
    logic signed [GAIN_W-1:0]   new_gain;
    logic [RAMP_W-1:0]          ramp_len;
    logic signed [SUM_W-1:0]    gain_diff;
    logic [GAIN_W-1:0]          diff_mag;
    logic                       div_start;
    logic                       div_done;
    logic signed [GAIN_W-1:0]   div_quotient;
    mix_ctrl_t                  mix_ctrl;
    logic signed [SAMPLE_W-1:0] mix_left;
    logic signed [SAMPLE_W-1:0] mix_right;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Frame-start gain and ramp setup
    assign new_gain  = quant_gain(predictor_index);
    assign ramp_len  = RAMP_W'(INTERP_MS * int'(rate_reg));
    assign gain_diff = SUM_W'(new_gain) - SUM_W'(prev_gain_reg);
    assign diff_mag  = gain_diff[SUM_W-1] ? GAIN_W'(-gain_diff) : GAIN_W'(gain_diff);

    msl_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (div_start),
        .dividend_mag (diff_mag),
        .negate       (gain_diff[SUM_W-1]),
        .divisor      (ramp_len),
        .done         (div_done),
        .quotient     (div_quotient)
    );

    msl_mix u_mix (
        .clk   (clk),
        .ctrl  (mix_ctrl),
        .gain  (gain_reg),
        .mid   (mid_reg),
        .side  (side_reg),
        .left  (mix_left),
        .right (mix_right)
    );

    // State and gain registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            rate_reg      <= RATE_RESET;
            prev_gain_reg <= '0;
            cur_gain_reg  <= '0;
            step_reg      <= '0;
            target_reg    <= '0;
            ramp_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            prev_gain_reg <= prev_gain_next;
            cur_gain_reg  <= cur_gain_next;
            step_reg      <= step_next;
            target_reg    <= target_next;
            ramp_reg      <= ramp_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                rate_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk) begin
        gain_reg <= gain_next;
        if (accept) begin
            mid_reg  <= mid_sample;
            side_reg <= side_sample;
        end
        if (out_load) begin
            left_reg  <= mix_left;
            right_reg <= mix_right;
        end
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        prev_gain_next = prev_gain_reg;
        cur_gain_next  = cur_gain_reg;
        step_next      = step_reg;
        target_next    = target_reg;
        ramp_next      = ramp_reg;
        gain_next      = gain_reg;
        div_start      = 1'b0;
        mix_ctrl       = '0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_GAIN;
                    if (frame_start) begin
                        target_next    = new_gain;
                        prev_gain_next = new_gain;
                        if (new_gain != prev_gain_reg && ramp_len != '0) begin
                            cur_gain_next = prev_gain_reg;
                            ramp_next     = ramp_len;
                            div_start     = 1'b1;
                            state_next    = ST_DIV;
                        end
                        else begin
                            ramp_next = '0;
                        end
                    end
                end
            end
            ST_DIV: begin
                // Wait for the ramp step
                if (div_done) begin
                    step_next  = div_quotient;
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN: begin
                // Advance the ramp or use the target gain
                if (ramp_reg != '0) begin
                    cur_gain_next = cur_gain_reg + step_reg;
                    ramp_next     = ramp_reg - 1'b1;
                    gain_next     = cur_gain_reg + step_reg;
                end
                else begin
                    gain_next = target_reg;
                end
                state_next = ST_MUL;
            end
            ST_MUL: begin
                mix_ctrl.mul_en = 1'b1;
                state_next      = ST_SUM;
            end
            ST_SUM: begin
                mix_ctrl.sum_en = 1'b1;
                state_next      = ST_OUT;
            end
            ST_OUT: begin
                // Hold until the output register frees up
                if (out_free) begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign left_sample  = left_reg;
    assign right_sample = right_reg;

endmodule

`default_nettype wire

### src/msl_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module msl_checker
    import msl_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                cfg_valid,
    input wire logic                cfg_ready,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire logic [SAMPLE_W-1:0] left_sample,
    input wire logic [SAMPLE_W-1:0] right_sample
);

    // A stalled result stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(left_sample) && $stable(right_sample))
        else $error("stalled result changed");

    // Block is busy right after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

    // A new result appears only at the end of an item's work
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without work in progress");

    // Configuration is always taken
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind mid_side_to_left_right msl_checker u_msl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .left_sample  (left_sample),
    .right_sample (right_sample)
);

`default_nettype wire

### tb/tb_mid_side_to_left_right.sv
`timescale 1ns / 1ps

module tb_mid_side_to_left_right;
    import msl_pkg::*;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

    typedef struct {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } lr_pair_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [RATE_W-1:0]          cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] mid_sample;
    logic signed [SAMPLE_W-1:0] side_sample;
    logic                       frame_start;
    logic [INDEX_W-1:0]         predictor_index;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;

    // Predictor copy of the stereo state
    int     rate_khz;
    longint last_gain;
    longint ramp_gain;
    longint ramp_step;
    longint frame_gain;
    longint ramp_left;

    lr_pair_t lr_expected_q[$];
    lr_pair_t want;
    int       fail_count  = 0;
    bit       tx_idle     = 1'b1;
    bit       rx_idle     = 1'b1;
    bit       rx_hold     = 1'b0;
    int       hold_cycles = 0;
    int       stall_left  = 0;

    mid_side_to_left_right DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mid_sample      (mid_sample),
        .side_sample     (side_sample),
        .frame_start     (frame_start),
        .predictor_index (predictor_index),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .left_sample     (left_sample),
        .right_sample    (right_sample)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Clamp to the 16-bit sample range
    function automatic logic signed [SAMPLE_W-1:0] clamp16(input longint v);
        if (v > 32767)
        begin
            return S_MAX;
        end
        if (v < -32768)
        begin
            return S_MIN;
        end
        return v[SAMPLE_W-1:0];
    endfunction

    // Advance the gain ramp by one item and form the left/right pair
    function automatic lr_pair_t predict_stereo(input logic signed [SAMPLE_W-1:0] mid,
                                                input logic signed [SAMPLE_W-1:0] side,
                                                input logic fs,
                                                input logic [INDEX_W-1:0] idx);
        longint   g;
        longint   ramp_len;
        longint   gain;
        longint   side_adj;
        lr_pair_t res;
        if (fs)
        begin
            g = longint'(GAIN_OFFSET)
                + longint'(idx) * ((longint'(1) << 17) / (QUANT_STEPS - 1));
            if (g > (longint'(1) << 17) - 1)
            begin
                g = (longint'(1) << 17) - 1;
            end
            if (g < -(longint'(1) << 17))
            begin
                g = -(longint'(1) << 17);
            end
            ramp_len   = longint'(INTERP_MS) * longint'(rate_khz);
            frame_gain = g;
            // Restart the ramp from the last latched gain, never from the ramped one
            if (frame_gain != last_gain && ramp_len > 0)
            begin
                ramp_gain = last_gain;
                ramp_step = (frame_gain - last_gain) / ramp_len;
                ramp_left = ramp_len;
            end
            else
            begin
                ramp_left = 0;
            end
            last_gain = frame_gain;
        end
        if (ramp_left > 0)
        begin
            ramp_gain += ramp_step;
            ramp_left--;
            gain = ramp_gain;
        end
        else
        begin
            gain = frame_gain;
        end
        side_adj  = clamp16(longint'(side) + ((gain * longint'(mid)) >>> 16));
        res.left  = clamp16(longint'(mid) + side_adj);
        res.right = clamp16(longint'(mid) - side_adj);
        return res;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return S_MAX;
            1: return S_MIN;
            2: return SAMPLE_W'($urandom_range(0, 32)) - 16'd16;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Offer one item, after a random gap when tx_idle is set, and record its expected pair on acceptance
    task automatic send_item(input logic signed [SAMPLE_W-1:0] mid,
                             input logic signed [SAMPLE_W-1:0] side,
                             input logic fs,
                             input logic [INDEX_W-1:0] idx);
        int gap;
        gap = tx_idle ? $urandom_range(0, 13) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid        <= 1'b1;
        mid_sample      <= mid;
        side_sample     <= side;
        frame_start     <= fs;
        predictor_index <= idx;
        do @(posedge clk); while (in_stall !== 1'b0);
        lr_expected_q.push_back(predict_stereo(mid, side, fs, idx));
    endtask

    task automatic drop_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (lr_expected_q.size() != 0) @(posedge clk);
    endtask

    // Write sample_rate_khz once the block has nothing in flight
    task automatic write_rate(input int khz);
        drop_input();
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= RATE_W'(khz);
        do @(posedge clk); while (cfg_ready !== 1'b1);
        rate_khz = khz;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Gain stays zero until the first frame start; index ignored without it
    task automatic test_no_frame_yet();
        send_item(S_MAX, S_MAX, 1'b0, 4'hF);
        send_item(S_MIN, S_MIN, 1'b0, 4'h0);
        send_item(16'sd0, S_MIN, 1'b0, 4'h7);
        send_item(S_MIN, S_MAX, 1'b0, 4'h0);
    endtask

    // Abandon a running ramp with a new frame start at the extreme indexes
    task automatic test_short_frame_restart();
        send_item(S_MAX, S_MAX, 1'b1, 4'hF);
        send_item(S_MIN, S_MAX, 1'b0, 4'h0);
        send_item(S_MIN, S_MIN, 1'b0, 4'hA);
        send_item(S_MAX, S_MIN, 1'b1, 4'h0);
        send_item(16'sd1, 16'sd0, 1'b0, 4'h0);
        send_item(-16'sd1, 16'sd0, 1'b0, 4'h0);
    endtask

    // Cancel the ramp when the frame repeats the latched gain
    task automatic test_unchanged_gain();
        send_item(16'sd12345, -16'sd4321, 1'b1, 4'h0);
        send_item(S_MIN, S_MAX, 1'b0, 4'h0);
    endtask

    // Apply the new gain at once with a zero-length ramp
    task automatic test_zero_ramp();
        write_rate(0);
        send_item(16'sd20000, -16'sd20000, 1'b1, 4'h8);
        send_item(-16'sd7, 16'sd3, 1'b0, 4'h0);
        send_item(S_MAX, 16'sd0, 1'b1, 4'hF);
        send_item(S_MIN, 16'sd0, 1'b0, 4'h0);
    endtask

    // Hold the sender mid-frame until every pair has come out
    task automatic test_sender_pause();
        write_rate(8);
        tx_idle = 1'b0;
        send_item(rand_sample(), rand_sample(), 1'b1, INDEX_W'($urandom));
        for (int k = 0; k < 19; k++)
        begin
            if (k == 9)
            begin
                drop_input();
                wait_drained();
            end
            send_item(rand_sample(), rand_sample(), 1'b0, INDEX_W'($urandom));
        end
        tx_idle = 1'b1;
    endtask

    // Stall the output for a long stretch while the sender keeps offering items
    task automatic test_output_hold();
        tx_idle     = 1'b0;
        hold_cycles = 300;
        send_item(rand_sample(), rand_sample(), 1'b1, INDEX_W'($urandom));
        for (int k = 0; k < 40; k++)
        begin
            send_item(rand_sample(), rand_sample(), 1'b0, INDEX_W'($urandom));
        end
        tx_idle = 1'b1;
    endtask

    // Random frames at one sample rate, mostly full length, some cut short
    task automatic test_random_frames(input int khz, input int n_items);
        int                 sent;
        int                 flen;
        int                 ramp_len;
        logic [INDEX_W-1:0] idx;
        write_rate(khz);
        ramp_len = INTERP_MS * khz;
        sent     = 0;
        idx      = INDEX_W'($urandom);
        while (sent < n_items)
        begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if (ramp_len == 0)
            begin
                flen = $urandom_range(1, 40);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                flen = $urandom_range(1, ramp_len);
            end
            else
            begin
                flen = ramp_len + $urandom_range(0, 24);
            end
            // Keep the index now and then so the gain repeats
            if ($urandom_range(0, 4) != 0)
            begin
                idx = INDEX_W'($urandom);
            end
            for (int k = 0; k < flen && sent < n_items; k++)
            begin
                send_item(rand_sample(), rand_sample(), k == 0,
                          (k == 0) ? idx : INDEX_W'($urandom));
                sent++;
            end
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // Count out the long output hold-off
    initial
    begin
        forever
        begin
            wait (hold_cycles > 0);
            rx_hold = 1'b1;
            repeat (hold_cycles) @(posedge clk);
            rx_hold     = 1'b0;
            hold_cycles = 0;
        end
    end

    // Drive the output stall from the long hold-off or the drawn wait
    always @(negedge clk)
    begin
        out_stall <= rx_hold || (stall_left > 0);
        if (stall_left > 0)
        begin
            stall_left--;
        end
    end

    // Compare each accepted pair with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (lr_expected_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("unexpected item: left %0d right %0d", left_sample, right_sample);
                end
            end
            else
            begin
                want = lr_expected_q.pop_front();
                if (left_sample !== want.left)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("left_sample mismatch: expected %0d, got %0d",
                                 want.left, left_sample);
                    end
                end
                if (right_sample !== want.right)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("right_sample mismatch: expected %0d, got %0d",
                                 want.right, right_sample);
                    end
                end
            end
            stall_left = rx_idle ? $urandom_range(0, 13) : 0;
        end
    end

    initial
    begin
        in_valid        = 1'b0;
        mid_sample      = '0;
        side_sample     = '0;
        frame_start     = 1'b0;
        predictor_index = '0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        rst_n           = 1'b0;
        rate_khz        = int'(RATE_RESET);
        last_gain       = 0;
        ramp_gain       = 0;
        ramp_step       = 0;
        frame_gain      = 0;
        ramp_left       = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_no_frame_yet();
        test_short_frame_restart();
        test_unchanged_gain();
        test_zero_ramp();
        test_sender_pause();
        test_output_hold();
        test_random_frames(8, 240);
        test_random_frames(31, 300);
        test_random_frames(24, 240);
        test_random_frames(1, 200);
        test_random_frames(0, 200);
        test_random_frames(16, 240);
        test_random_frames(13, 200);

        // Let the last pairs come out, then watch for strays
        drop_input();
        wait_drained();
        repeat (30) @(posedge clk);
        if (fail_count == 0 && lr_expected_q.size() == 0)
        begin
            $display("** mid_side_to_left_right: PASSED **");
        end
        else
        begin
            $display("** mid_side_to_left_right: FAILED **");
        end
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2_000_000;
        $display("** mid_side_to_left_right: FAILED **");
        $finish;
    end

endmodule

### sim.f
src/msl_pkg.sv
src/msl_div.sv
src/msl_mix.sv
src/mid_side_to_left_right.sv
src/msl_checker.sv
tb/tb_mid_side_to_left_right.sv
